FILE: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer.
// Used by text_console_writer, tcw_checker and text_console_writer_tb; depends on nothing.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CELL_W      = 16;
	localparam int PADDR_W     = 3;

	localparam logic [7:0] ATTR_RESET     = 8'h07;
	localparam logic [7:0] CH_NEWLINE     = 8'd10;
	localparam logic [7:0] CH_RETURN      = 8'd13;
	localparam logic [7:0] CH_BACKSPACE   = 8'd8;
	localparam logic [7:0] CH_SPACE       = 8'd32;
	localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
	localparam logic [7:0] CH_LAST_PRINT  = 8'd126;

	// register index taken from paddr[2]
	localparam logic REG_ATTR = 1'b0;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} tcw_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK,
		ST_HOLD
	} tcw_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tcw_cmd_word_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_position;
		logic [15:0] cell_value;
	} tcw_rsp_word_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
// tcw_ram: generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/text_console_writer.sv
// text_console_writer: character-cell text console with cursor, scroll and clear.
// Depends on tcw_pkg and tcw_ram (screen memory).
//
// Usage:
//   Command channel (cmd_valid/cmd_ready/cmd_word) takes put, clear and read words;
//   every command gives exactly one word on the response channel
//   (rsp_valid/rsp_ready/rsp_word) with the cursor after the command and, for a
//   read, the cell (zero when the index is off the screen).
//   The APB port holds the attribute byte used for written and blanked cells.
// Timing:
//   Put without scroll: result registered as the command is taken, if the output is free.
//   Read: the cell passes through the registered memory read, then into the result.
//   Put that scrolls: one cell copy per cycle
//   through the single memory read and write port.
//   Clear: one cell per cycle.
// Reset:
//   Cursor homes, attribute becomes 7, and a clearing pass writes blank cells to all
//   COLUMNS*ROWS cells; cmd_ready stays low until it ends.
// Stall:
//   A finished word waits in the output register; one further command is taken
//   and its result parked until the receiver takes the first.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  tcw_cmd_word_t        cmd_word,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output tcw_rsp_word_t        rsp_word,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);

	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
	localparam logic [AW-1:0] BOT_ROW   = AW'(CELL_COUNT - COLUMNS);

	tcw_state_t    state_q, state_d;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   fill_q;
	logic          owe_q;
	logic [7:0]    attr_q;
	tcw_rsp_word_t hold_q;
	logic          rsp_valid_q;
	tcw_rsp_word_t rsp_word_q;
	logic          rd_ok_s1;
	logic          copy_s1;
	logic [AW-1:0] copy_addr_s1;

	logic          accept, out_free, fin, cfg_wr;
	logic [AW-1:0] cur_pos;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic          scroll_req, put_we;
	logic [AW-1:0] put_addr;
	logic [15:0]   put_data;
	tcw_rsp_word_t res_nxt;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;

	function automatic tcw_rsp_word_t make_res(logic [CW-1:0] col, logic [RW-1:0] row,
	                                           logic [15:0] cell_val);
		tcw_rsp_word_t r;
		logic [AW-1:0] pos;
		pos               = AW'(row) * COL_STEP + AW'(col);
		r.cursor_column   = 7'(col);
		r.cursor_row      = 5'(row);
		r.cursor_position = 11'(pos);
		r.cell_value      = cell_val;
		return r;
	endfunction

	assign accept   = cmd_valid && cmd_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign cur_pos  = AW'(row_q) * COL_STEP + AW'(col_q);
	assign cfg_wr   = psel && penable && pwrite;

	// put decode
	always_comb begin
		nxt_col    = col_q;
		nxt_row    = row_q;
		scroll_req = 1'b0;
		put_we     = 1'b0;
		put_addr   = cur_pos;
		put_data   = {attr_q, cmd_word.char_code};
		if (cmd_word.char_code == CH_NEWLINE) begin
			nxt_col = '0;
			if (row_q == LAST_ROW) begin
				scroll_req = 1'b1;
			end else begin
				nxt_row = row_q + 1'b1;
			end
		end else if (cmd_word.char_code == CH_RETURN) begin
			nxt_col = '0;
		end else if (cmd_word.char_code == CH_BACKSPACE) begin
			put_addr = cur_pos - 1'b1;
			put_data = {attr_q, CH_SPACE};
			if (col_q != '0) begin
				nxt_col = col_q - 1'b1;
				put_we  = 1'b1;
			end else if (row_q != '0) begin
				nxt_col = LAST_COL;
				nxt_row = row_q - 1'b1;
				put_we  = 1'b1;
			end
		end else if (cmd_word.char_code inside {[CH_FIRST_PRINT:CH_LAST_PRINT]}) begin
			put_we = 1'b1;
			if (col_q == LAST_COL) begin
				nxt_col = '0;
				if (row_q == LAST_ROW) begin
					scroll_req = 1'b1;
				end else begin
					nxt_row = row_q + 1'b1;
				end
			end else begin
				nxt_col = col_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_word.command)
						CMD_PUT:   state_d = scroll_req ? ST_SCROLL :
						                     (out_free ? ST_IDLE : ST_HOLD);
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_READ:  state_d = ST_READ;
						default:   state_d = out_free ? ST_IDLE : ST_HOLD;
					endcase
				end
			end
			ST_READ:   state_d = out_free ? ST_IDLE : ST_HOLD;
			ST_CLEAR: begin
				if (idx_q == LAST_CELL) begin
					state_d = (owe_q && !out_free) ? ST_HOLD : ST_IDLE;
				end
			end
			ST_SCROLL: begin
				if (idx_q == LAST_CELL) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (!copy_s1 && idx_q == LAST_CELL) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD:   state_d = out_free ? ST_IDLE : ST_HOLD;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine: memory port controls and result
	always_comb begin
		cmd_ready = 1'b0;
		fin       = 1'b0;
		res_nxt   = make_res(col_q, row_q, 16'h0000);
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = fill_q;
		if (copy_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (accept) begin
					case (cmd_word.command)
						CMD_PUT: begin
							ram_we    = put_we;
							ram_waddr = put_addr;
							ram_wdata = put_data;
							fin       = !scroll_req;
							res_nxt   = make_res(nxt_col, nxt_row, 16'h0000);
						end
						CMD_CLEAR: begin
						end
						CMD_READ: begin
							ram_re    = 1'b1;
							ram_raddr = AW'(cmd_word.cell_index);
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				fin     = 1'b1;
				res_nxt = make_res(col_q, row_q, rd_ok_s1 ? ram_rdata : 16'h0000);
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				fin    = owe_q && (idx_q == LAST_CELL);
			end
			ST_SCROLL: begin
				ram_re = 1'b1;
			end
			ST_BLANK: begin
				if (!copy_s1) begin
					ram_we    = 1'b1;
					ram_wdata = {attr_q, CH_SPACE};
					fin       = (idx_q == LAST_CELL);
				end
			end
			ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			col_q       <= '0;
			row_q       <= '0;
			idx_q       <= '0;
			fill_q      <= {ATTR_RESET, CH_SPACE};
			owe_q       <= 1'b0;
			attr_q      <= ATTR_RESET;
			rsp_valid_q <= 1'b0;
			copy_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			copy_s1 <= (state_q == ST_SCROLL);
			if (cfg_wr && paddr[PADDR_W-1:2] == REG_ATTR) begin
				attr_q <= pwdata[7:0];
			end
			if (accept) begin
				case (cmd_word.command)
					CMD_PUT: begin
						col_q <= nxt_col;
						row_q <= nxt_row;
						idx_q <= COL_STEP;
					end
					CMD_CLEAR: begin
						col_q  <= '0;
						row_q  <= '0;
						idx_q  <= '0;
						fill_q <= {attr_q, CH_SPACE};
						owe_q  <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_CLEAR:  idx_q <= idx_q + 1'b1;
				ST_SCROLL: idx_q <= (idx_q == LAST_CELL) ? BOT_ROW : idx_q + 1'b1;
				ST_BLANK: begin
					if (!copy_s1) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (fin && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (state_q == ST_HOLD && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		copy_addr_s1 <= idx_q - COL_STEP;
		if (accept) begin
			rd_ok_s1 <= (32'(cmd_word.cell_index) < 32'(CELL_COUNT));
		end
		if (fin && out_free) begin
			rsp_word_q <= res_nxt;
		end else if (state_q == ST_HOLD && out_free) begin
			rsp_word_q <= hold_q;
		end
		if (fin && !out_free) begin
			hold_q <= res_nxt;
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[PADDR_W-1:2] == REG_ATTR) ? {24'h000000, attr_q} : 32'h0;

endmodule

FILE: hw/rtl/tcw_checker.sv
// tcw_checker: port-level assertions for text_console_writer, bound to the top level.
// Depends on tcw_pkg.
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input tcw_cmd_word_t cmd_word,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input tcw_rsp_word_t rsp_word
);

	localparam bit EXACT = (COLUMNS <= 128) && (ROWS <= 32);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("response word changed while stalled");

	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && EXACT |->
			rsp_word.cursor_position ==
			11'(32'(rsp_word.cursor_row) * COLUMNS + 32'(rsp_word.cursor_column)) &&
			32'(rsp_word.cursor_row) < ROWS && 32'(rsp_word.cursor_column) < COLUMNS)
		else $error("cursor fields inconsistent");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_word.command == CMD_CLEAR |=>
			!cmd_ready ##1 !cmd_ready)
		else $error("command taken during clear sweep");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_word.command == CMD_READ |=> !cmd_ready)
		else $error("command taken during read latency");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcw_checker (.*);

FILE: tb/text_console_writer_tb.sv
// text_console_writer_tb: self-checking bench for the text console writer.
// Drives command words and APB attribute writes, predicts the screen and cursor.
// Depends on tcw_pkg and text_console_writer.
module text_console_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLS  = COLUMNS_DEF;
	localparam int ROWS  = ROWS_DEF;
	localparam int CELLS = COLS * ROWS;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] ATTR_ADDR = '0;	// text_attribute, register 0
	localparam int PHASES = 5;
	localparam int PHASE_WORDS = 86;

	class console_scoreboard;
		logic [15:0] screen [CELLS];
		int unsigned col, row;
		logic [7:0] attr;
		tcw_rsp_word_t expected [$];
		int errors, puts, reads, clears, unused, scrolls;

		function new();
			attr = ATTR_RESET;
			blank_screen();
		endfunction

		function void blank_screen();
			foreach (screen[i]) screen[i] = {attr, CH_SPACE};
			col = 0;
			row = 0;
		endfunction

		function void note_command(tcw_cmd_word_t w);
			tcw_rsp_word_t r;
			r = '0;
			case (w.command)
			CMD_PUT: begin
				puts++;
				if (w.char_code == CH_NEWLINE) begin
					col = 0;
					row++;
				end else if (w.char_code == CH_RETURN) begin
					col = 0;
				end else if (w.char_code == CH_BACKSPACE) begin
					if (col > 0) begin
						col--;
						screen[row * COLS + col] = {attr, CH_SPACE};
					end else if (row > 0) begin
						col = COLS - 1;
						row--;
						screen[row * COLS + col] = {attr, CH_SPACE};
					end
				end else if (w.char_code >= CH_FIRST_PRINT && w.char_code <= CH_LAST_PRINT) begin
					screen[row * COLS + col] = {attr, w.char_code};
					col++;
					if (col >= COLS) begin
						col = 0;
						row++;
					end
				end
				if (row >= ROWS) begin
					scrolls++;
					for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
					for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
					col = 0;
					row = ROWS - 1;
				end
			end
			CMD_CLEAR: begin
				clears++;
				blank_screen();
			end
			CMD_READ: begin
				reads++;
				if (w.cell_index < CELLS) r.cell_value = screen[w.cell_index];
			end
			default: unused++;
			endcase
			r.cursor_column   = 7'(col);
			r.cursor_row      = 5'(row);
			r.cursor_position = 11'(row * COLS + col);
			expected.push_back(r);
		endfunction

		function void check_response(tcw_rsp_word_t got);
			tcw_rsp_word_t want;
			if (expected.size() == 0) begin
				$error("response word %h with nothing expected", got);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (got.cursor_column !== want.cursor_column) begin
				$error("cursor_column: expected %0d, got %0d", want.cursor_column,
					got.cursor_column);
				errors++;
			end
			if (got.cursor_row !== want.cursor_row) begin
				$error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
				errors++;
			end
			if (got.cursor_position !== want.cursor_position) begin
				$error("cursor_position: expected %0d, got %0d", want.cursor_position,
					got.cursor_position);
				errors++;
			end
			if (got.cell_value !== want.cell_value) begin
				$error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	tcw_cmd_word_t cmd_word = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	tcw_rsp_word_t rsp_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	console_scoreboard sb = new();
	bit send_idle = 1'b1;
	bit rsp_idle = 1'b1;
	int stall_left = 0;
	int sent_count = 0;
	int attr_settings = 0;

	text_console_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word(cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word(rsp_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver: check on handshake, then pick next ready
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_response(rsp_word);
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			stall_left = pick_gap(rsp_idle);
		end
	end

	task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch,
		input logic [10:0] idx);
		tcw_cmd_word_t w;
		int gap;
		w.command    = cmd;
		w.char_code  = ch;
		w.cell_index = idx;
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do @(posedge clk); while (!cmd_ready);
		sb.note_command(w);
		sent_count++;
		gap = pick_gap(send_idle);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	task automatic apb_attr(input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.attr = value;
		attr_settings++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== {24'h0, value}) begin
			$error("text_attribute readback: expected %h, got %h", value, prdata);
			sb.errors++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(input int words);
		int target, r, n, k, pos;
		target = sent_count + words;
		while (sent_count < target) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// a line of text, now and then long enough to wrap
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 8);
				repeat (n) send_word(CMD_PUT, 8'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)),
					11'($urandom));
				k = $urandom_range(0, 99);
				if (k < 70) send_word(CMD_PUT, CH_NEWLINE, 11'($urandom));
				else if (k < 85) send_word(CMD_PUT, CH_RETURN, 11'($urandom));
			end else if (r < 70) begin
				repeat ($urandom_range(1, 10)) send_word(CMD_PUT, CH_NEWLINE, 11'($urandom));
			end else if (r < 78) begin
				repeat ($urandom_range(1, 5)) send_word(CMD_PUT, CH_BACKSPACE, 11'($urandom));
			end else if (r < 88) begin
				repeat ($urandom_range(1, 3)) begin
					pos = sb.row * COLS + sb.col;
					if ($urandom_range(0, 1) == 0) k = $urandom_range(0, 2047);
					else k = pos - $urandom_range(0, (pos < 100) ? pos : 100);
					send_word(CMD_READ, 8'($urandom), 11'(k));
				end
			end else if (r < 93) begin
				send_word(CMD_PUT, 8'($urandom), 11'($urandom));
			end else if (r < 95) begin
				send_word(CMD_UNUSED, 8'($urandom), 11'($urandom));
			end else if (r < 97) begin
				send_word(CMD_CLEAR, 8'($urandom), 11'($urandom));
			end else if (r < 99) begin
				send_word(2'($urandom), 8'($urandom), 11'($urandom));
			end else begin
				wait_drained();
			end
		end
	endtask

	initial begin
		#100ms;
		$display("text_console_writer_tb: FAIL");
		$finish;
	end

	initial begin
		logic [7:0] attr_value;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// screen clearing pass after reset
		do @(posedge clk); while (!cmd_ready);

		// directed words, reset attribute
		send_word(CMD_READ, 8'h00, 11'd0);
		send_word(CMD_READ, 8'hFF, 11'(CELLS - 1));
		send_word(CMD_READ, 8'h00, 11'(CELLS));
		send_word(CMD_READ, 8'h00, 11'h7FF);
		send_word(CMD_PUT, CH_BACKSPACE, 11'd0);
		send_word(CMD_PUT, CH_FIRST_PRINT, 11'd0);
		send_word(CMD_PUT, CH_LAST_PRINT, 11'h7FF);
		send_word(CMD_PUT, 8'd31, 11'd0);
		send_word(CMD_PUT, 8'd127, 11'd0);
		send_word(CMD_PUT, 8'd255, 11'd0);
		send_word(CMD_PUT, 8'd0, 11'd0);
		send_word(CMD_PUT, CH_RETURN, 11'd0);
		send_word(CMD_PUT, 8'h41, 11'd0);
		send_word(CMD_PUT, CH_NEWLINE, 11'd0);
		send_word(CMD_PUT, CH_BACKSPACE, 11'd0);
		send_word(CMD_READ, 8'h00, 11'(COLS - 1));
		send_word(CMD_PUT, 8'h7A, 11'd0);
		send_word(CMD_UNUSED, 8'hFF, 11'h7FF);
		send_word(CMD_READ, 8'h00, 11'd0);
		send_word(CMD_CLEAR, 8'h00, 11'd0);
		send_word(CMD_READ, 8'h00, 11'd1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			attr_value = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(1, 254));
			apb_attr(attr_value);
			send_idle = !(p == 1 || p == 2);
			rsp_idle  = !(p == 1 || p == 3);
			run_random(PHASE_WORDS);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Run covered %0d command words: %0d puts, %0d reads, %0d clears, %0d unused.",
			sent_count, sb.puts, sb.reads, sb.clears, sb.unused);
		$display("Screen scrolled %0d times over %0d attribute settings.",
			sb.scrolls, attr_settings);
		if (sb.errors == 0 && sb.expected.size() == 0) begin
			$display("text_console_writer_tb: PASS");
		end else begin
			$display("text_console_writer_tb: FAIL");
		end
		$finish;
	end

endmodule
